// ----- design/hpr_pkg.sv -----
// Shared widths, stage map, limits and register indexes for the haze pixel recovery unit.
package hpr_pkg;

    localparam int PIX_W       = 8;
    localparam int GAIN_W      = 16;
    localparam int NUM_W       = 2 * PIX_W;
    localparam int PROD_W      = GAIN_W + PIX_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TDATA_W     = 4 * PIX_W;

    // Stage map: front end, lane front end, multiply, divide stages, output register.
    localparam int DIV_STAGES      = 4;
    localparam int DIV_STEPS       = NUM_W / DIV_STAGES;
    localparam int LANE_STAGE      = 1;
    localparam int MULT_STAGE      = 2;
    localparam int FIRST_DIV_STAGE = 3;
    localparam int NUM_STAGES      = DIV_STAGES + 4;

    // 0.9 in Q0.16, truncated.
    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'd58982;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HAZE_GAIN   = 3'd0,
        CFG_ATMOS_BLUE  = 3'd1,
        CFG_ATMOS_GREEN = 3'd2,
        CFG_ATMOS_RED   = 3'd3,
        CFG_LIGHT_CAP   = 3'd4
    } cfg_index_t;

endpackage

// ----- design/hpr_lane.sv -----
// One colour channel of the recovery datapath: difference, product, pipelined divide and select.
module hpr_lane (
    input  logic                             clk,
    input  logic [hpr_pkg::NUM_STAGES-1:1]   en,
    input  hpr_pkg::pix_t                    raw,
    input  hpr_pkg::pix_t                    atmos,
    input  hpr_pkg::pix_t                    dark,
    input  hpr_pkg::pix_t                    cap,
    output hpr_pkg::pix_t                    recovered
);
    import hpr_pkg::*;

    typedef struct packed {
        pix_t             rem;
        logic [NUM_W-1:0] acc;
        logic [NUM_W-1:0] num;
        pix_t             raw;
        pix_t             den_mag;
        logic             den_neg;
        logic             den_zero;
    } div_t;

    // Restoring division, four quotient bits per stage. The dividend shifts out of acc
    // from the top while the quotient bits fill it from the bottom.
    function automatic div_t div_step(div_t d_in);
        div_t           d;
        logic [PIX_W:0] t;
        d = d_in;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            t     = {d.rem, d.acc[NUM_W-1]};
            d.acc = {d.acc[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, d.den_mag})
            begin
                d.rem    = PIX_W'(t - {1'b0, d.den_mag});
                d.acc[0] = 1'b1;
            end
            else
            begin
                d.rem = t[PIX_W-1:0];
            end
        end
        return d;
    endfunction

    logic [PIX_W:0]   den_full;
    logic             den_neg;
    pix_t             den_mag;

    pix_t             raw1_reg;
    pix_t             diff1_reg;
    pix_t             den_mag1_reg;
    logic             den_neg1_reg;
    logic             den_zero1_reg;

    logic [NUM_W-1:0] num_prod;
    div_t             div_reg [0:DIV_STAGES];

    logic [NUM_W-1:0] quo;
    logic [NUM_W-1:0] val;
    pix_t             neg_byte;
    pix_t             recovered_next;
    pix_t             recovered_reg;

    // The sign of atmos minus dark decides how the quotient is treated at the end.
    always_comb
    begin
        den_full = {1'b0, atmos} - {1'b0, dark};
        den_neg  = den_full[PIX_W];
        den_mag  = den_neg ? PIX_W'(-den_full) : den_full[PIX_W-1:0];
    end

    // Dark never exceeds the smallest channel, so the difference cannot go negative.
    always_ff @(posedge clk)
    begin
        if (en[LANE_STAGE])
        begin
            raw1_reg      <= raw;
            diff1_reg     <= raw - dark;
            den_mag1_reg  <= den_mag;
            den_neg1_reg  <= den_neg;
            den_zero1_reg <= (den_full == '0);
        end
    end

    assign num_prod = NUM_W'(atmos) * NUM_W'(diff1_reg);

    always_ff @(posedge clk)
    begin
        if (en[MULT_STAGE])
        begin
            div_reg[0].rem      <= '0;
            div_reg[0].acc      <= num_prod;
            div_reg[0].num      <= num_prod;
            div_reg[0].raw      <= raw1_reg;
            div_reg[0].den_mag  <= den_mag1_reg;
            div_reg[0].den_neg  <= den_neg1_reg;
            div_reg[0].den_zero <= den_zero1_reg;
        end
    end

    for (genvar i = 1; i <= DIV_STAGES; i++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en[FIRST_DIV_STAGE + i - 1])
            begin
                div_reg[i] <= div_step(div_reg[i-1]);
            end
        end
    end

    // A negative divisor gives a quotient of zero or below, which never exceeds the cap.
    always_comb
    begin
        quo      = div_reg[DIV_STAGES].acc;
        val      = div_reg[DIV_STAGES].den_zero ? div_reg[DIV_STAGES].num : quo;
        neg_byte = PIX_W'(NUM_W'(0) - quo);
        if (div_reg[DIV_STAGES].den_neg)
        begin
            recovered_next = neg_byte;
        end
        else if (val > NUM_W'(cap))
        begin
            recovered_next = div_reg[DIV_STAGES].raw;
        end
        else
        begin
            recovered_next = val[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
        begin
            recovered_reg <= recovered_next;
        end
    end

    assign recovered = recovered_reg;

endmodule

// ----- design/haze_pixel_recovery_unit.sv -----
// Top level of the haze pixel recovery unit: configuration, front end, lanes and handshake.
// An accepted request moves from the front end through the lane front end, multiply and divide stages to the output.
// Throughput: one pixel per cycle unless the output stalls; eight register stages, four of them the divide.
// A stalled output holds its stage while empty stages behind it keep filling.
// Reset empties the pipeline, sets haze_gain to 0 and the light and cap registers to 255.
module haze_pixel_recovery_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hpr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // blue_in, green_in, red_in, local_average (lowest bits first)
    input  logic [hpr_pkg::TDATA_W-1:0]       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // dark_value, blue_out, green_out, red_out (lowest bits first)
    output logic [hpr_pkg::TDATA_W-1:0]       m_axis_tdata
);
    import hpr_pkg::*;

    logic [GAIN_W-1:0]     haze_gain_reg;
    pix_t                  atmos_blue_reg;
    pix_t                  atmos_green_reg;
    pix_t                  atmos_red_reg;
    pix_t                  light_cap_reg;
    logic [GAIN_W-1:0]     gain_wr;

    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] valid_reg;

    pix_t                  blue_in;
    pix_t                  green_in;
    pix_t                  red_in;
    pix_t                  local_average;
    pix_t                  minch;
    logic [PROD_W-1:0]     gain_prod;

    pix_t                  blue0_reg;
    pix_t                  green0_reg;
    pix_t                  red0_reg;
    pix_t                  minch0_reg;
    pix_t                  scaled0_reg;

    pix_t                  dark_next;
    pix_t                  dark_reg [1:NUM_STAGES-1];

    pix_t                  blue_out;
    pix_t                  green_out;
    pix_t                  red_out;

    // The gain is clamped as it is written, so the datapath sees it already limited.
    assign gain_wr = (cfg_wdata > GAIN_MAX) ? GAIN_MAX : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            haze_gain_reg   <= '0;
            atmos_blue_reg  <= '1;
            atmos_green_reg <= '1;
            atmos_red_reg   <= '1;
            light_cap_reg   <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HAZE_GAIN:   haze_gain_reg   <= gain_wr;
                CFG_ATMOS_BLUE:  atmos_blue_reg  <= cfg_wdata[PIX_W-1:0];
                CFG_ATMOS_GREEN: atmos_green_reg <= cfg_wdata[PIX_W-1:0];
                CFG_ATMOS_RED:   atmos_red_reg   <= cfg_wdata[PIX_W-1:0];
                CFG_LIGHT_CAP:   light_cap_reg   <= cfg_wdata[PIX_W-1:0];
                default:         ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];

    assign blue_in       = s_axis_tdata[PIX_W-1:0];
    assign green_in      = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign red_in        = s_axis_tdata[3*PIX_W-1:2*PIX_W];
    assign local_average = s_axis_tdata[4*PIX_W-1:3*PIX_W];

    always_comb
    begin
        minch = (blue_in < green_in) ? blue_in : green_in;
        if (red_in < minch)
        begin
            minch = red_in;
        end
        gain_prod = PROD_W'(haze_gain_reg) * PROD_W'(local_average);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            blue0_reg   <= blue_in;
            green0_reg  <= green_in;
            red0_reg    <= red_in;
            minch0_reg  <= minch;
            scaled0_reg <= gain_prod[PROD_W-1:GAIN_W];
        end
    end

    assign dark_next = (scaled0_reg < minch0_reg) ? scaled0_reg : minch0_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dark_reg[1] <= dark_next;
        end
        for (int k = 2; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                dark_reg[k] <= dark_reg[k-1];
            end
        end
    end

    hpr_lane u_lane_blue (
        .clk       (clk),
        .en        (en[NUM_STAGES-1:1]),
        .raw       (blue0_reg),
        .atmos     (atmos_blue_reg),
        .dark      (dark_next),
        .cap       (light_cap_reg),
        .recovered (blue_out)
    );

    hpr_lane u_lane_green (
        .clk       (clk),
        .en        (en[NUM_STAGES-1:1]),
        .raw       (green0_reg),
        .atmos     (atmos_green_reg),
        .dark      (dark_next),
        .cap       (light_cap_reg),
        .recovered (green_out)
    );

    hpr_lane u_lane_red (
        .clk       (clk),
        .en        (en[NUM_STAGES-1:1]),
        .raw       (red0_reg),
        .atmos     (atmos_red_reg),
        .dark      (dark_next),
        .cap       (light_cap_reg),
        .recovered (red_out)
    );

    assign m_axis_tdata = {red_out, green_out, blue_out, dark_reg[NUM_STAGES-1]};

endmodule
